// ===== design/nkro_pkg.sv =====
package nkro_pkg;

    localparam int BOOT_LEN     = 8;
    localparam int BITMAP_START = 2;
    localparam int FIRST_KEY    = 4;
    localparam int SLOT_MAX     = 6;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int KEY_W     = 7;
    localparam int KEY_CNT_W = 3;
    localparam int INDEX_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_NKRO  = 2'd0,
        KIND_BOOT  = 2'd1,
        KIND_OTHER = 2'd2
    } t_report_kind;

    typedef struct packed {
        logic [BOOT_LEN-1:0][BYTE_W-1:0] bytes;
        t_report_kind                    kind;
    } t_report;

endpackage

// ===== design/nkro_accum.sv =====
module nkro_accum
    import nkro_pkg::*;
#(
    parameter int NKRO_LEN = 15,
    parameter int MAX_KEYS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_report           o_report
);

    logic [COUNT_W-1:0]                r_byte_count, n_byte_count;
    logic [BOOT_LEN-1:0][BYTE_W-1:0]   r_raw_head,   n_raw_head;
    logic [MAX_KEYS-1:0][KEY_W-1:0]    r_key_slots,  n_key_slots;
    logic [KEY_CNT_W-1:0]              r_key_count,  n_key_count;

    logic              in_map;
    logic [KEY_W-1:0]  code;

    always_comb begin
        n_raw_head  = r_raw_head;
        n_key_slots = r_key_slots;
        n_key_count = r_key_count;
        code        = '0;

        if (r_byte_count < COUNT_W'(BOOT_LEN)) begin
            n_raw_head[r_byte_count[INDEX_W-1:0]] = i_byte;
        end

        n_byte_count = (r_byte_count == COUNT_MAX) ? COUNT_MAX : r_byte_count + 1'b1;

        in_map = (r_byte_count >= COUNT_W'(BITMAP_START))
              && (r_byte_count < COUNT_W'(NKRO_LEN));

        // keycode = (pos - 2) * 8 + bit, low bits first, take the first free slot
        for (int b = 0; b < BYTE_W; b++) begin
            code = {r_byte_count[3:0] - 4'd2, 3'(b)};
            if (in_map && i_byte[b] && code >= KEY_W'(FIRST_KEY)
                    && n_key_count < KEY_CNT_W'(MAX_KEYS)) begin
                for (int k = 0; k < MAX_KEYS; k++) begin
                    if (n_key_count == KEY_CNT_W'(k)) begin
                        n_key_slots[k] = code;
                    end
                end
                n_key_count = n_key_count + 1'b1;
            end
        end
    end

    // unused slots and bytes are zero, so the report is built straight from state
    always_comb begin
        o_report.bytes = n_raw_head;
        if (n_byte_count == COUNT_W'(NKRO_LEN)) begin
            o_report.kind     = KIND_NKRO;
            o_report.bytes    = '0;
            o_report.bytes[0] = n_raw_head[0];
            for (int k = 0; k < MAX_KEYS; k++) begin
                o_report.bytes[BITMAP_START+k] = BYTE_W'(n_key_slots[k]);
            end
        end else if (n_byte_count == COUNT_W'(BOOT_LEN)) begin
            o_report.kind = KIND_BOOT;
        end else begin
            o_report.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_raw_head   <= '0;
            r_key_slots  <= '0;
            r_key_count  <= '0;
        end else if (i_valid) begin
            if (i_last) begin
                r_byte_count <= '0;
                r_raw_head   <= '0;
                r_key_slots  <= '0;
                r_key_count  <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_raw_head   <= n_raw_head;
                r_key_slots  <= n_key_slots;
                r_key_count  <= n_key_count;
            end
        end
    end

    a_key_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KEY_CNT_W'(MAX_KEYS))
        else $error("key count above limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |=> r_byte_count == '0 && r_key_count == '0)
        else $error("state not cleared after last byte");

endmodule

// ===== design/nkro_out.sv =====
module nkro_out
    import nkro_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_report            i_report,
    input  logic               i_stall,
    output logic               o_busy,
    output logic               o_valid,
    output logic [BYTE_W-1:0]  o_byte,
    output logic [INDEX_W-1:0] o_index,
    output logic               o_last,
    output logic [1:0]         o_kind
);

    logic                            r_valid, n_valid;
    logic [INDEX_W-1:0]              r_index, n_index;
    logic [BOOT_LEN-1:0][BYTE_W-1:0] r_bytes;
    t_report_kind                    r_kind;
    logic                            take;

    assign take    = r_valid && !i_stall;
    // free again in the cycle the eighth byte goes out, so the next report loads without a gap
    assign o_busy  = r_valid && !(take && o_last);
    assign o_valid = r_valid;
    assign o_byte  = r_bytes[r_index];
    assign o_index = r_index;
    assign o_last  = (r_index == INDEX_W'(BOOT_LEN - 1));
    assign o_kind  = r_kind;

    always_comb begin
        n_valid = r_valid;
        n_index = r_index;
        if (i_load) begin
            n_valid = 1'b1;
            n_index = '0;
        end else if (take) begin
            n_index = r_index + 1'b1;
            if (o_last) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_index <= '0;
        end else begin
            r_valid <= n_valid;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_report.bytes;
            r_kind  <= i_report.kind;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_valid || (take && o_last))
        else $error("report loaded over one still draining");

    a_done_after_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && o_last && !i_load |=> !r_valid)
        else $error("output still valid after eighth byte");

endmodule

// ===== design/nkro_to_boot_report_converter.sv =====
// Input bytes: one per cycle while o_in_stall is low; each is registered in the input register
// and then folded into the report state. The last byte of a report then loads the output buffer,
// which sends its eight bytes from byte 0 on, holding each while i_out_stall is high. The last byte
// of a report waits in the input register while the previous report still drains from the output
// buffer; it moves on at the edge that takes the previous report's eighth byte.
// Reset: synchronous, active low; clears the byte count, stored bytes, keys and both valids.
module nkro_to_boot_report_converter
    import nkro_pkg::*;
#(
    parameter int NKRO_LEN = 15,
    parameter int MAX_KEYS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_report_byte,
    input  logic               i_last_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic [INDEX_W-1:0] o_out_index,
    output logic               o_out_last,
    output logic [1:0]         o_report_kind
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              in_take;
    logic              advance;
    logic              out_busy;
    t_report           report;

    // a last byte moves on only when the output buffer is free
    assign advance    = r_in_valid && (!r_in_last || !out_busy);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_report_byte;
            r_in_last <= i_last_in;
        end
    end

    nkro_accum #(
        .NKRO_LEN (NKRO_LEN),
        .MAX_KEYS (MAX_KEYS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_report (report)
    );

    nkro_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_in_last),
        .i_report (report),
        .i_stall  (i_out_stall),
        .o_busy   (out_busy),
        .o_valid  (o_out_valid),
        .o_byte   (o_out_byte),
        .o_index  (o_out_index),
        .o_last   (o_out_last),
        .o_kind   (o_report_kind)
    );

    a_hold_last_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && out_busy |=> r_in_valid)
        else $error("last byte dropped while output busy");

endmodule

// ===== tb/nkro_to_boot_report_converter_tb.sv =====
module nkro_to_boot_report_converter_tb;
    import nkro_pkg::*;

    localparam int NKRO_LEN       = 15;
    localparam int MAX_KEYS       = 6;
    localparam int RANDOM_ITEMS   = 286;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
        t_report_kind       kind;
    } t_boot_byte;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              golden;
        t_report           rpt;
    } t_stim_row;

    localparam t_report NO_REPORT = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_report_byte;
    logic               i_last_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [BYTE_W-1:0]  o_out_byte;
    logic [INDEX_W-1:0] o_out_index;
    logic               o_out_last;
    logic [1:0]         o_report_kind;

    // Shadow of the block's report state
    logic [COUNT_W-1:0]   acc_count = '0;
    logic [BYTE_W-1:0]    acc_head [BOOT_LEN];
    logic [KEY_W-1:0]     acc_keys [SLOT_MAX];
    logic [KEY_CNT_W-1:0] acc_nkeys = '0;

    t_boot_byte pending_boot_bytes [$];

    int      fail_count  = 0;
    int      idle_cycles = 0;
    logic    quiet_in    = 1'b0;
    logic    quiet_out   = 1'b0;
    logic    drain_before_next = 1'b0;
    logic    row_golden  = 1'b0;
    t_report row_report  = '0;

    // Directed reports; typed-in boot reports hold byte 0 in the low bits.
    t_stim_row stim_rows [DIR_ROWS] = '{
        // 8-byte passthrough with extreme values
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'h80, 1'b0, 1'b0, NO_REPORT},
        '{8'h7F, 1'b0, 1'b0, NO_REPORT},
        '{8'h01, 1'b0, 1'b0, NO_REPORT},
        '{8'hFE, 1'b0, 1'b0, NO_REPORT},
        '{8'h55, 1'b0, 1'b0, NO_REPORT},
        '{8'hAA, 1'b1, 1'b1, '{bytes: 64'hAA55_FE01_7F80_FF00, kind: KIND_BOOT}},
        // single-byte report, truncated kind
        '{8'hFF, 1'b1, 1'b1, '{bytes: 64'h0000_0000_0000_00FF, kind: KIND_OTHER}},
        // NKRO: codes 0..3 skipped, 4..9 kept, the seventh key dropped
        '{8'hE2, 1'b0, 1'b0, NO_REPORT},
        '{8'h5A, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'h03, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h80, 1'b1, 1'b1, '{bytes: 64'h0908_0706_0504_00E2, kind: KIND_NKRO}}
    };

    nkro_to_boot_report_converter #(
        .NKRO_LEN(NKRO_LEN),
        .MAX_KEYS(MAX_KEYS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_report_byte (i_report_byte),
        .i_last_in     (i_last_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_out_index   (o_out_index),
        .o_out_last    (o_out_last),
        .o_report_kind (o_report_kind)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < BOOT_LEN; i++) acc_head[i] = '0;
        for (int i = 0; i < SLOT_MAX; i++) acc_keys[i] = '0;
    end

    // Folds one report byte into the shadow state; on the last byte returns the boot report.
    task automatic fold_report_byte(input logic [BYTE_W-1:0] data, input logic last,
                                    output logic done, output t_report rpt);
        logic [COUNT_W-1:0] pos;
        logic [COUNT_W-1:0] len;
        int code;
        pos = acc_count;
        len = (pos == COUNT_MAX) ? COUNT_MAX : pos + 5'd1;
        if (pos < BOOT_LEN) acc_head[pos] = data;
        if (pos >= BITMAP_START && pos < NKRO_LEN) begin
            for (int b = 0; b < 8; b++) begin
                code = (int'(pos) - BITMAP_START) * 8 + b;
                if (data[b] && code >= FIRST_KEY && acc_nkeys < MAX_KEYS) begin
                    acc_keys[acc_nkeys] = code[KEY_W-1:0];
                    acc_nkeys = acc_nkeys + 3'd1;
                end
            end
        end
        acc_count = len;
        rpt  = '0;
        done = last;
        if (last) begin
            if (len == NKRO_LEN) begin
                rpt.kind     = KIND_NKRO;
                rpt.bytes[0] = acc_head[0];
                for (int i = 0; i < acc_nkeys; i++) rpt.bytes[2 + i] = {1'b0, acc_keys[i]};
            end else if (len == BOOT_LEN) begin
                rpt.kind = KIND_BOOT;
                for (int i = 0; i < BOOT_LEN; i++) rpt.bytes[i] = acc_head[i];
            end else begin
                rpt.kind = KIND_OTHER;
                for (int i = 0; i < BOOT_LEN && i < len; i++) rpt.bytes[i] = acc_head[i];
            end
            acc_count = '0;
            acc_nkeys = '0;
            for (int i = 0; i < BOOT_LEN; i++) acc_head[i] = '0;
            for (int i = 0; i < SLOT_MAX; i++) acc_keys[i] = '0;
        end
    endtask

    // Offers one byte and returns at the falling edge after its transaction.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last,
                             input logic golden, input t_report rpt);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 18);
        if (drain_before_next) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (pending_boot_bytes.size() != 0);
            drain_before_next = 1'b0;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_report_byte <= data;
        i_last_in     <= last;
        row_golden = golden;
        row_report = rpt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_boot_byte want;
        t_report    rpt;
        logic       done;
        logic       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_boot_bytes.size() == 0) begin
                    $error("unexpected boot byte %0h at index %0d", o_out_byte, o_out_index);
                    fail_count++;
                end else begin
                    want = pending_boot_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                        fail_count++;
                    end
                    if (o_out_index !== want.index) begin
                        $error("out_index: expected %0d, got %0d", want.index, o_out_index);
                        fail_count++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, o_out_last);
                        fail_count++;
                    end
                    if (o_report_kind !== want.kind) begin
                        $error("report_kind: expected %0d, got %0d", want.kind, o_report_kind);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                fold_report_byte(i_report_byte, i_last_in, done, rpt);
                if (done) begin
                    if (row_golden) rpt = row_report;
                    for (int i = 0; i < BOOT_LEN; i++)
                        pending_boot_bytes.push_back('{rpt.bytes[i], 3'(i),
                                                       i == BOOT_LEN - 1, rpt.kind});
                end
            end
        end
        if (moved) idle_cycles = 0;
        else idle_cycles++;
    end

    initial begin : receiver
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = quiet_out ? 0 : $urandom_range(0, 18);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int  items_sent;
        int  reports_sent;
        int  len;
        int  pick;
        logic sparse;
        logic [BYTE_W-1:0] data;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_report_byte = '0;
        i_last_in     = 1'b0;
        items_sent    = 0;
        reports_sent  = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(stim_rows[r].data, stim_rows[r].last, stim_rows[r].golden,
                      stim_rows[r].rpt);

        drain_before_next = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            sparse    = $urandom_range(0, 1);
            pick      = $urandom_range(0, 99);
            if (pick < 45) len = NKRO_LEN;
            else if (pick < 70) len = BOOT_LEN;
            else if (pick < 95) len = $urandom_range(1, 20);
            else len = $urandom_range(31, 40);   // saturates the byte count
            if (reports_sent == 12) drain_before_next = 1'b1;
            for (int p = 0; p < len; p++) begin
                if (sparse && p >= BITMAP_START && p < NKRO_LEN)
                    data = ($urandom_range(0, 5) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
                else
                    data = 8'($urandom);
                send_byte(data, p == len - 1, 1'b0, NO_REPORT);
            end
            items_sent += len;
            reports_sent++;
        end
        i_in_valid <= 1'b0;

        while (pending_boot_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
